>>> design/mac_pkg.sv
`default_nettype none
package mac_pkg;

  localparam int unsigned SLOT_W   = 4;
  localparam int unsigned AMOUNT_W = 48;
  localparam int unsigned SPARE_W  = 48;
  localparam int unsigned WORKER_W = 16;
  localparam int unsigned DEMAND_W = 52;
  localparam int unsigned SUM_W    = 64;
  localparam int unsigned STATUS_W = 3;

  typedef enum logic [1:0] {
    CMD_REGISTER = 2'd0,
    CMD_CLAIM    = 2'd1,
    CMD_RELEASE  = 2'd2,
    CMD_REPORT   = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    ST_OK     = 3'd0,
    ST_DENIED = 3'd1,
    ST_UNREG  = 3'd2,
    ST_DUP    = 3'd3,
    ST_UNDER  = 3'd4
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_READ,
    S_EXEC,
    S_WALK_RD,
    S_WALK_ACC,
    S_DIV,
    S_FINISH,
    S_OUT
  } state_e;

  // controller to datapath
  typedef struct packed {
    logic load;
    logic rd;
    logic walk;
    logic exec_single;
    logic acc_clr;
    logic acc_add;
    logic div_go;
    logic acc_div;
    logic idx_inc;
    logic finish_claim;
    logic out_load;
  } ctrl_t;

  // datapath to controller
  typedef struct packed {
    cmd_e cmd;
    logic cmd_valid;
    logic need_div;
    logic is_last;
    logic div_busy;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

>>> design/mac_ctrl.sv
`default_nettype none
module mac_ctrl
  import mac_pkg::*;
(
  input  logic  clk_i,
  input  logic  rst_ni,
  input  logic  in_valid_i,
  output logic  in_ready_o,
  input  stat_t stat_i,
  output ctrl_t ctrl_o
);

  state_e state_q, state_d;

  // state register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // sequence one command at a time
  always_comb begin
    state_d    = state_q;
    ctrl_o     = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          ctrl_o.load = 1'b1;
          state_d     = S_READ;
        end
      end
      S_READ: begin
        ctrl_o.rd = 1'b1;
        state_d   = S_EXEC;
      end
      S_EXEC: begin
        if (stat_i.cmd == CMD_CLAIM && stat_i.cmd_valid) begin
          ctrl_o.acc_clr = 1'b1;
          state_d        = S_WALK_RD;
        end else begin
          ctrl_o.exec_single = 1'b1;
          state_d            = S_OUT;
        end
      end
      S_WALK_RD: begin
        ctrl_o.rd   = 1'b1;
        ctrl_o.walk = 1'b1;
        state_d     = S_WALK_ACC;
      end
      S_WALK_ACC: begin
        ctrl_o.acc_add = 1'b1;
        if (stat_i.need_div) begin
          ctrl_o.div_go = 1'b1;
          state_d       = S_DIV;
        end else if (stat_i.is_last) begin
          state_d = S_FINISH;
        end else begin
          ctrl_o.idx_inc = 1'b1;
          state_d        = S_WALK_RD;
        end
      end
      S_DIV: begin
        if (!stat_i.div_busy) begin
          ctrl_o.acc_div = 1'b1;
          if (stat_i.is_last) begin
            state_d = S_FINISH;
          end else begin
            ctrl_o.idx_inc = 1'b1;
            state_d        = S_WALK_RD;
          end
        end
      end
      S_FINISH: begin
        ctrl_o.finish_claim = 1'b1;
        state_d             = S_OUT;
      end
      S_OUT: begin
        if (stat_i.out_free) begin
          ctrl_o.out_load = 1'b1;
          state_d         = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule
`default_nettype wire

>>> design/mac_datapath.sv
`default_nettype none
module mac_datapath
  import mac_pkg::*;
#(
  parameter int unsigned MAX_SCANS = 16,
  parameter int unsigned MEM_BITS  = 48
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  ctrl_t                ctrl_i,
  output stat_t                stat_o,
  input  logic [1:0]           cmd_i,
  input  logic [SLOT_W-1:0]    slot_i,
  input  logic [AMOUNT_W-1:0]  amount_i,
  input  logic [SPARE_W-1:0]   spare_i,
  output logic                 out_valid_o,
  input  logic                 out_ready_i,
  output logic                 granted_o,
  output logic [STATUS_W-1:0]  status_o,
  output logic [DEMAND_W-1:0]  demand_o
);

  localparam int unsigned IDX_W = (MAX_SCANS > 1) ? $clog2(MAX_SCANS) : 1;
  localparam int unsigned DW    = MEM_BITS + 2;
  localparam int unsigned CNT_W = $clog2(DW + 1);
  localparam logic [SUM_W-1:0] DEMAND_MAX = SUM_W'((65'd1 << DEMAND_W) - 65'd1);
  localparam logic [MEM_BITS-1:0] MEM_MAX = '1;
  localparam logic [WORKER_W-1:0] WRK_MAX = '1;

  // slot table
  logic                valid_q [MAX_SCANS];
  logic [MEM_BITS-1:0] est_q   [MAX_SCANS];
  logic [MEM_BITS-1:0] cons_q  [MAX_SCANS];
  logic [WORKER_W-1:0] wrk_q   [MAX_SCANS];

  // latched command
  cmd_e                cmd_q;
  logic [SLOT_W-1:0]   slot_q;
  logic [MEM_BITS-1:0] amt_q;
  logic [SPARE_W-1:0]  spare_q;
  logic [63:0]         amt64;

  assign amt64 = 64'(amount_i);

  always_ff @(posedge clk_i) begin
    if (ctrl_i.load) begin
      cmd_q   <= cmd_e'(cmd_i);
      slot_q  <= slot_i;
      amt_q   <= amt64[MEM_BITS-1:0];
      spare_q <= spare_i;
    end
  end

  logic [31:0]      slot_ext;
  logic [IDX_W-1:0] slot_idx;
  logic             slot_ok;

  assign slot_ext = 32'(slot_q);
  assign slot_idx = slot_ext[IDX_W-1:0];
  assign slot_ok  = slot_ext < MAX_SCANS;

  // walk counter
  logic [IDX_W:0] idx_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q <= '0;
    end else if (ctrl_i.acc_clr) begin
      idx_q <= '0;
    end else if (ctrl_i.idx_inc) begin
      idx_q <= idx_q + 1'b1;
    end
  end

  // registered table read
  logic [IDX_W-1:0]    rd_addr;
  logic                v_rd_q, clm_rd_q;
  logic [MEM_BITS-1:0] e_rd_q, c_rd_q;
  logic [WORKER_W-1:0] w_rd_q;

  assign rd_addr = ctrl_i.walk ? idx_q[IDX_W-1:0] : slot_idx;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.rd) begin
      v_rd_q   <= valid_q[rd_addr];
      e_rd_q   <= est_q[rd_addr];
      c_rd_q   <= cons_q[rd_addr];
      w_rd_q   <= wrk_q[rd_addr];
      clm_rd_q <= (rd_addr == slot_idx);
    end
  end

  logic over;
  assign over = c_rd_q > e_rd_q;

  // serial restoring divider for 3*C / (2*W)
  logic                busy_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [DW-1:0]       dvd_q;
  logic [WORKER_W:0]   dvs_q;
  logic [WORKER_W:0]   rem_q;
  logic [WORKER_W+1:0] rem_sh;
  logic                q_bit;
  logic [WORKER_W+1:0] rem_sub;

  assign rem_sh  = {rem_q, dvd_q[DW-1]};
  assign q_bit   = rem_sh >= {1'b0, dvs_q};
  assign rem_sub = rem_sh - {1'b0, dvs_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q  <= '0;
    end else if (ctrl_i.div_go) begin
      busy_q <= 1'b1;
      cnt_q  <= CNT_W'(DW);
    end else if (busy_q) begin
      cnt_q <= cnt_q - 1'b1;
      if (cnt_q == CNT_W'(1)) begin
        busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.div_go) begin
      dvd_q <= DW'(c_rd_q) + (DW'(c_rd_q) << 1);
      dvs_q <= {((w_rd_q == '0) ? WORKER_W'(1) : w_rd_q), 1'b0};
      rem_q <= '0;
    end else if (busy_q) begin
      rem_q <= q_bit ? rem_sub[WORKER_W:0] : rem_sh[WORKER_W:0];
      dvd_q <= {dvd_q[DW-2:0], q_bit};
    end
  end

  // saturating demand accumulator
  logic [SUM_W-1:0] sum_q, add_val;
  logic [SUM_W:0]   sum_wide;

  always_comb begin
    if (ctrl_i.acc_div) begin
      add_val = SUM_W'(dvd_q);
    end else if (over) begin
      add_val = SUM_W'(c_rd_q >> 1);
    end else begin
      add_val = SUM_W'(e_rd_q - c_rd_q) + (clm_rd_q ? SUM_W'(amt_q) : '0);
    end
    if (!v_rd_q && !ctrl_i.acc_div) begin
      add_val = '0;
    end
  end

  assign sum_wide = {1'b0, sum_q} + {1'b0, add_val};

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_clr) begin
      sum_q <= '0;
    end else if (ctrl_i.acc_add || ctrl_i.acc_div) begin
      sum_q <= sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];
    end
  end

  // hold the claimer's entry for the final update
  logic [MEM_BITS-1:0] ce_q;
  logic [WORKER_W-1:0] cw_q;

  always_ff @(posedge clk_i) begin
    if (ctrl_i.acc_add && clm_rd_q) begin
      ce_q <= e_rd_q;
      cw_q <= w_rd_q;
    end
  end

  // grant decision and growth
  logic             grant;
  logic [MEM_BITS:0] grow;

  assign grant = !spare_q[SPARE_W-1] && (spare_q != '0) && (sum_q < SUM_W'(spare_q));
  assign grow  = {1'b0, ce_q} + {1'b0, amt_q};

  // release arithmetic
  logic                e_ge;
  logic [MEM_BITS-1:0] e_rel;
  logic [WORKER_W-1:0] w_rel;

  assign e_ge  = e_rd_q >= amt_q;
  assign e_rel = e_ge ? (e_rd_q - amt_q) : '0;
  assign w_rel = (w_rd_q != '0) ? (w_rd_q - 1'b1) : '0;

  // table update and pending result
  status_e             res_st_q;
  logic                res_gr_q;
  logic [DEMAND_W-1:0] res_dm_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < MAX_SCANS; i++) begin
        valid_q[i] <= 1'b0;
      end
    end else if (ctrl_i.exec_single && cmd_q == CMD_REGISTER && slot_ok && !v_rd_q) begin
      valid_q[slot_idx] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.exec_single) begin
      res_gr_q <= 1'b0;
      res_dm_q <= '0;
      priority if (cmd_q == CMD_REGISTER) begin
        if (!slot_ok) begin
          res_st_q <= ST_UNREG;
        end else if (v_rd_q) begin
          res_st_q <= ST_DUP;
        end else begin
          res_st_q         <= ST_OK;
          est_q[slot_idx]  <= amt_q;
          wrk_q[slot_idx]  <= WORKER_W'(1);
          cons_q[slot_idx] <= '0;
        end
      end else if (!(slot_ok && v_rd_q)) begin
        res_st_q <= ST_UNREG;
      end else if (cmd_q == CMD_REPORT) begin
        res_st_q         <= ST_OK;
        cons_q[slot_idx] <= amt_q;
      end else begin
        est_q[slot_idx] <= e_rel;
        wrk_q[slot_idx] <= w_rel;
        res_st_q        <= (!e_ge || w_rd_q == '0) ? ST_UNDER : ST_OK;
      end
    end else if (ctrl_i.finish_claim) begin
      res_dm_q <= (sum_q > DEMAND_MAX) ? DEMAND_MAX[DEMAND_W-1:0] : sum_q[DEMAND_W-1:0];
      res_gr_q <= grant;
      res_st_q <= grant ? ST_OK : ST_DENIED;
      if (grant) begin
        est_q[slot_idx] <= grow[MEM_BITS] ? MEM_MAX : grow[MEM_BITS-1:0];
        wrk_q[slot_idx] <= (cw_q == WRK_MAX) ? cw_q : cw_q + 1'b1;
      end
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (ctrl_i.out_load) begin
      out_valid_o <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.out_load) begin
      granted_o <= res_gr_q;
      status_o  <= res_st_q;
      demand_o  <= res_dm_q;
    end
  end

  // status to controller
  assign stat_o.cmd       = cmd_q;
  assign stat_o.cmd_valid = slot_ok && v_rd_q;
  assign stat_o.need_div  = v_rd_q && clm_rd_q && over;
  assign stat_o.is_last   = (idx_q == (IDX_W + 1)'(MAX_SCANS - 1));
  assign stat_o.div_busy  = busy_q;
  assign stat_o.out_free  = !out_valid_o || out_ready_i;

endmodule
`default_nettype wire

>>> design/memory_admission_controller.sv
// Memory admission controller over a table of MAX_SCANS scan slots.
// Input stream s_axis: one word per command (register, claim, release,
// report). Output stream m_axis: exactly one result word per command.
// One command is processed at a time; s_axis_tready is high only while
// the controller waits for a command.
// Register, release, report and an unregistered claim pass through the
// read, execute and output states only. A claim walks every slot through
// the single table read port, reading and then accumulating each slot, and
// runs the serial divider when the claiming slot is over its estimate.
// The result sits in an output register; a stalled receiver holds the
// result, the block finishes the next command and then waits for the
// output register to drain.
// Reset clears all slot valid bits at once; no clearing pass is needed.
`default_nettype none
module memory_admission_controller
  import mac_pkg::*;
#(
  parameter int unsigned MAX_SCANS = 16,
  parameter int unsigned MEM_BITS  = 48
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // command[1:0], scan_slot[5:2], amount[53:6], spare_capacity[101:54]
  input  logic [103:0] s_axis_tdata,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // granted[0], status[3:1], extra_demand[55:4]
  output logic [55:0]  m_axis_tdata
);

  ctrl_t ctrl;
  stat_t stat;
  logic                granted;
  logic [STATUS_W-1:0] status;
  logic [DEMAND_W-1:0] demand;

  mac_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid),
    .in_ready_o (s_axis_tready),
    .stat_i     (stat),
    .ctrl_o     (ctrl)
  );

  mac_datapath #(
    .MAX_SCANS (MAX_SCANS),
    .MEM_BITS  (MEM_BITS)
  ) u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .stat_o      (stat),
    .cmd_i       (s_axis_tdata[1:0]),
    .slot_i      (s_axis_tdata[5:2]),
    .amount_i    (s_axis_tdata[53:6]),
    .spare_i     (s_axis_tdata[101:54]),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .granted_o   (granted),
    .status_o    (status),
    .demand_o    (demand)
  );

  assign m_axis_tdata = {demand, status, granted};

  // a granted claim always reports ok
  a_grant_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && granted) |-> (status == ST_OK))
    else $error("granted result with non-ok status");

  // one command at a time: no accept right after an accept
  a_one_at_a_time: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("input accepted while a command is in progress");

  // divider never runs outside a claim walk
  a_div_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stat.div_busy |-> !s_axis_tready)
    else $error("divider busy while idle");

endmodule
`default_nettype wire

>>> verif/memory_admission_controller_checker.sv
module memory_admission_controller_checker
  import mac_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_valid_i,
  input  logic         s_ready_i,
  input  logic [103:0] s_data_i,
  input  logic         m_valid_i,
  input  logic         m_ready_i,
  input  logic [55:0]  m_data_i,
  output int           fail_count_o,
  output int           pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] MEM_MASK = 64'hFFFF_FFFF_FFFF;
  localparam logic [63:0] DEMAND_MAX = (64'd1 << 52) - 64'd1;

  // packed from the top bit down: demand, status, granted
  typedef struct packed {
    logic [51:0] demand;
    status_e     status;
    logic        granted;
  } admit_t;

  logic        slot_on  [16];
  logic [63:0] slot_est [16];
  logic [15:0] slot_wrk [16];
  logic [63:0] slot_used[16];
  admit_t      admit_q[$];
  int          fails;

  assign fail_count_o = fails;
  assign pending_o    = admit_q.size();

  function automatic logic [63:0] sat_sum(logic [63:0] a, logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  // advance the table by one command and return its verdict
  function automatic admit_t admit_word(logic [103:0] w);
    cmd_e        cmd;
    logic [3:0]  sl;
    logic [63:0] amt, spare, sum, d, wk, ne;
    logic        under;
    admit_t      r;
    cmd   = cmd_e'(w[1:0]);
    sl    = w[5:2];
    amt   = {16'd0, w[53:6]};
    spare = {16'd0, w[101:54]};
    r     = '{granted: 1'b0, status: ST_OK, demand: '0};
    if (cmd == CMD_REGISTER) begin
      if (slot_on[sl]) begin
        r.status = ST_DUP;
      end else begin
        slot_on[sl]   = 1'b1;
        slot_est[sl]  = amt;
        slot_wrk[sl]  = 16'd1;
        slot_used[sl] = '0;
      end
    end else if (!slot_on[sl]) begin
      r.status = ST_UNREG;
    end else if (cmd == CMD_REPORT) begin
      slot_used[sl] = amt;
    end else if (cmd == CMD_RELEASE) begin
      under = 1'b0;
      if (slot_est[sl] >= amt) slot_est[sl] -= amt;
      else begin
        slot_est[sl] = '0;
        under = 1'b1;
      end
      if (slot_wrk[sl] != 0) slot_wrk[sl] -= 16'd1;
      else under = 1'b1;
      if (under) r.status = ST_UNDER;
    end else begin
      sum = '0;
      for (int i = 0; i < 16; i++) begin
        if (slot_on[i]) begin
          if (slot_used[i] > slot_est[i]) begin
            d = slot_used[i] >> 1;
            if (i == sl) begin
              wk = (slot_wrk[i] == 0) ? 64'd1 : {48'd0, slot_wrk[i]};
              d = sat_sum(d, (64'd3 * slot_used[i]) / (64'd2 * wk));
            end
          end else begin
            d = slot_est[i] - slot_used[i];
            if (i == sl) d = sat_sum(d, amt);
          end
          sum = sat_sum(sum, d);
        end
      end
      r.demand = (sum > DEMAND_MAX) ? DEMAND_MAX[51:0] : sum[51:0];
      if (!spare[47] && spare != 0 && sum < spare) begin
        ne = slot_est[sl] + amt;
        slot_est[sl] = (ne > MEM_MASK) ? MEM_MASK : ne;
        if (slot_wrk[sl] != 16'hFFFF) slot_wrk[sl] += 16'd1;
        r.granted = 1'b1;
      end else begin
        r.status = ST_DENIED;
      end
    end
    return r;
  endfunction

  // predict on each accepted command word, compare each result word
  always @(posedge clk_i or negedge rst_ni) begin
    admit_t got, want;
    if (!rst_ni) begin
      fails = 0;
      admit_q.delete();
      for (int i = 0; i < 16; i++) begin
        slot_on[i] = 1'b0;
        slot_est[i] = '0;
        slot_wrk[i] = '0;
        slot_used[i] = '0;
      end
    end else begin
      if (s_valid_i && s_ready_i) admit_q.push_back(admit_word(s_data_i));
      if (m_valid_i && m_ready_i) begin
        got = admit_t'(m_data_i);
        if (admit_q.size() == 0) begin
          $error("result word with nothing expected: %h", m_data_i);
          fails++;
        end else begin
          want = admit_q.pop_front();
          if (got.granted !== want.granted) begin
            $error("granted: expected %0d, got %0d", want.granted, got.granted);
            fails++;
          end
          if (got.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, got.status);
            fails++;
          end
          if (got.demand !== want.demand) begin
            $error("extra_demand: expected %0d, got %0d", want.demand, got.demand);
            fails++;
          end
        end
      end
    end
  end
endmodule

>>> verif/memory_admission_controller_test.sv
module memory_admission_controller_test;
  import mac_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT = 600000;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_valid = 1'b0;
  logic         s_ready;
  logic [103:0] s_data = '0;
  logic         m_valid;
  logic         m_ready = 1'b0;
  logic [55:0]  m_data;
  int           fail_count, pending, cycles;
  logic         hold_off = 1'b0;
  logic         stim_done = 1'b0;

  memory_admission_controller dut (
    .clk_i, .rst_ni,
    .s_axis_tvalid(s_valid), .s_axis_tready(s_ready), .s_axis_tdata(s_data),
    .m_axis_tvalid(m_valid), .m_axis_tready(m_ready), .m_axis_tdata(m_data)
  );

  memory_admission_controller_checker chk (
    .clk_i, .rst_ni,
    .s_valid_i(s_valid), .s_ready_i(s_ready), .s_data_i(s_data),
    .m_valid_i(m_valid), .m_ready_i(m_ready), .m_data_i(m_data),
    .fail_count_o(fail_count), .pending_o(pending)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic logic [47:0] rand_bytes();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return '1;
      2: return 48'($urandom_range(0, 4000));
      3: return {16'd0, $urandom()};
      default: return 48'({$urandom(), $urandom()} >> $urandom_range(0, 40));
    endcase
  endfunction

  function automatic logic [47:0] rand_spare();
    case ($urandom_range(0, 6))
      0: return '0;
      1: return 48'h8000_0000_0000;
      2: return 48'h7FFF_FFFF_FFFF;
      3: return 48'({$urandom(), $urandom()});
      default: return 48'({$urandom(), $urandom()} >> $urandom_range(15, 50));
    endcase
  endfunction

  // offer one command word, wait for its handshake
  task automatic send_word(cmd_e cmd, logic [3:0] sl, logic [47:0] amt,
                           logic [47:0] spare);
    int gap;
    gap = $urandom_range(0, 5);
    if ($urandom_range(0, 3) == 0) gap = 0;
    if (gap > 0) begin
      s_valid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_data  <= {2'b00, spare, amt, sl, cmd};
    s_valid <= 1'b1;
    @(posedge clk_i);
    while (!s_ready) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // receiver: random stalls, plus a long hold-off on request
  initial begin
    int stall;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (hold_off) begin
        m_ready <= 1'b0;
      end else begin
        stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 5);
        if (stall > 0) begin
          m_ready <= 1'b0;
          repeat (stall) @(negedge clk_i);
        end
        m_ready <= 1'b1;
        @(posedge clk_i);
        while (!m_valid) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (300) @(negedge clk_i);
    hold_off = 1'b1;
    repeat (2000) @(negedge clk_i);
    hold_off = 1'b0;
  end

  // stimulus
  initial begin
    logic [3:0] sl;
    int pick;
    repeat (10) @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);
    // directed: unregistered, duplicates, saturation, underflow, denials
    send_word(CMD_CLAIM, 4'd15, '1, 48'd100);
    send_word(CMD_RELEASE, 4'd0, '0, '0);
    send_word(CMD_REPORT, 4'd3, '1, '0);
    send_word(CMD_REGISTER, 4'd0, '1, '1);
    send_word(CMD_REGISTER, 4'd0, 48'd5, '0);
    send_word(CMD_CLAIM, 4'd0, '1, 48'h7FFF_FFFF_FFFF);
    send_word(CMD_CLAIM, 4'd0, '1, 48'h8000_0000_0000);
    send_word(CMD_REGISTER, 4'd15, 48'd1000, '0);
    send_word(CMD_CLAIM, 4'd15, 48'd10, '0);
    send_word(CMD_CLAIM, 4'd15, 48'd10, '1);
    send_word(CMD_CLAIM, 4'd15, 48'd10, 48'h7FFF_FFFF_FFFF);
    send_word(CMD_REPORT, 4'd15, 48'd999_999, '0);
    send_word(CMD_CLAIM, 4'd15, 48'd1, 48'h7FFF_FFFF_FFFF);
    send_word(CMD_RELEASE, 4'd15, '1, '0);
    send_word(CMD_RELEASE, 4'd15, 48'd0, '0);
    send_word(CMD_RELEASE, 4'd15, 48'd0, '0);
    send_word(CMD_RELEASE, 4'd15, 48'd0, '0);
    send_word(CMD_CLAIM, 4'd15, 48'd7, 48'h7FFF_FFFF_FFFF);
    send_word(CMD_REPORT, 4'd0, '1, '0);
    send_word(CMD_CLAIM, 4'd0, '1, 48'h0000_0000_0001);
    // random: mostly registered slots with registers, claims, releases and reports
    for (int n = 0; n < 1000; n++) begin
      sl = 4'($urandom_range(0, 15));
      pick = $urandom_range(0, 99);
      if (pick < 12) send_word(CMD_REGISTER, sl, rand_bytes(), rand_spare());
      else if (pick < 50) send_word(CMD_CLAIM, sl, rand_bytes(), rand_spare());
      else if (pick < 72) send_word(CMD_RELEASE, sl, rand_bytes(), rand_spare());
      else send_word(CMD_REPORT, sl, rand_bytes(), rand_spare());
    end
    s_valid <= 1'b0;
    stim_done = 1'b1;
  end

  // verdict
  initial begin
    cycles = 0;
    @(posedge rst_ni);
    while (!(stim_done && pending == 0) && cycles < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycles++;
    end
    if (cycles >= CYCLE_LIMIT) begin
      $display("memory_admission_controller_test: FAIL");
    end else begin
      repeat (100) @(posedge clk_i);
      if (fail_count == 0 && pending == 0) begin
        $display("memory_admission_controller_test: PASS");
      end else begin
        $display("memory_admission_controller_test: FAIL");
      end
    end
    $finish;
  end
endmodule
